@@ src/nsc_pkg.sv @@
// Package for the NMEA sentence checker: verdict types, fault codes and character constants.
package nsc_pkg;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int LEN_W = 10;
	localparam logic [LEN_W-1:0] LEN_SAT = 10'd1023;
	localparam logic [LEN_W-1:0] MIN_LENGTH_RESET = 10'd11;
	localparam logic [0:0] REG_MIN_LENGTH = 1'b0;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_NL = 8'h0A;

	typedef enum logic [2:0] {
		FAULT_OK       = 3'd0,
		FAULT_SHORT    = 3'd1,
		FAULT_FRAMING  = 3'd2,
		FAULT_CHECKSUM = 3'd3,
		FAULT_OVERLONG = 3'd4
	} fault_t;

	typedef struct packed {
		logic             ok;
		fault_t           fault;
		logic [LEN_W-1:0] length;
		logic [7:0]       chk;
	} verdict_t;

	typedef struct packed {
		logic head_valid;
		logic skid_valid;
	} buf_status_t;

	// Uppercase ASCII hex digit of a nibble.
	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] r;
		if (v < 4'd10) begin
			r = 8'h30 + {4'd0, v};
		end else begin
			r = 8'h41 + {4'd0, v} - 8'd10;
		end
		return r;
	endfunction

endpackage

@@ src/nsc_line_tracker.sv @@
// Per-line state of the checker and the verdict for a line that ends with the current byte.
module nsc_line_tracker #(
	parameter int MAX_LINE = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [7:0]               data_byte,
	input  logic [nsc_pkg::LEN_W-1:0] min_length,
	output nsc_pkg::verdict_t        verdict
);

	localparam int CNT_W = $clog2(MAX_LINE);
	localparam int LW = (CNT_W + 1 > nsc_pkg::LEN_W) ? CNT_W + 1 : nsc_pkg::LEN_W;
	localparam int OVL_SHOWN = (MAX_LINE - 1 > 1023) ? 1023 : MAX_LINE - 1;

	logic [CNT_W-1:0] count_q;
	logic [7:0]       lead_q;
	logic [7:0]       tail_q [4];
	logic [7:0]       xor_q;
	logic             overlong_q;

	logic             is_nl;
	logic [CNT_W:0]   len_w;
	logic [LW-1:0]    len_ext;
	logic             short_line;
	logic [7:0]       chk;

	assign is_nl = (data_byte == nsc_pkg::CH_NL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			lead_q <= '0;
			xor_q <= '0;
			overlong_q <= 1'b0;
			for (int i = 0; i < 4; i++) tail_q[i] <= '0;
		end else if (accept) begin
			if (is_nl) begin
				count_q <= '0;
				lead_q <= '0;
				xor_q <= '0;
				overlong_q <= 1'b0;
				for (int i = 0; i < 4; i++) tail_q[i] <= '0;
			end else if (!overlong_q) begin
				if (count_q == '0) begin
					lead_q <= data_byte;
				end else begin
					xor_q <= xor_q ^ data_byte;
				end
				for (int i = 3; i > 0; i--) tail_q[i] <= tail_q[i-1];
				tail_q[0] <= data_byte;
				count_q <= count_q + 1'b1;
				if (count_q >= CNT_W'(MAX_LINE - 2)) overlong_q <= 1'b1;
			end
		end
	end

	assign len_w = {1'b0, count_q} + 1'b1;
	assign len_ext = LW'(len_w);
	assign short_line = (count_q < CNT_W'(5));
	assign chk = short_line ? 8'h00 : (xor_q ^ tail_q[0] ^ tail_q[1] ^ tail_q[2] ^ tail_q[3]);

	always_comb begin
		verdict.ok = 1'b0;
		verdict.fault = nsc_pkg::FAULT_OK;
		verdict.chk = chk;
		verdict.length = (len_ext > LW'(nsc_pkg::LEN_SAT)) ? nsc_pkg::LEN_SAT
			: len_ext[nsc_pkg::LEN_W-1:0];
		if (overlong_q) begin
			verdict.fault = nsc_pkg::FAULT_OVERLONG;
			verdict.chk = 8'h00;
			verdict.length = nsc_pkg::LEN_W'(OVL_SHOWN);
		end else if (len_ext <= LW'(min_length)) begin
			verdict.fault = nsc_pkg::FAULT_SHORT;
		end else if (short_line || lead_q != nsc_pkg::CH_DOLLAR
				|| tail_q[3] != nsc_pkg::CH_STAR) begin
			verdict.fault = nsc_pkg::FAULT_FRAMING;
		end else if (tail_q[2] != nsc_pkg::hex_digit(chk[7:4])
				|| tail_q[1] != nsc_pkg::hex_digit(chk[3:0])) begin
			verdict.fault = nsc_pkg::FAULT_CHECKSUM;
		end else begin
			verdict.ok = 1'b1;
		end
	end

endmodule

@@ src/nsc_result_buffer.sv @@
// Two-slot result buffer: output register plus skid slot between the tracker and the result channel.
module nsc_result_buffer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  nsc_pkg::verdict_t    push_data,
	input  logic                 out_ready,
	output logic                 out_valid,
	output nsc_pkg::verdict_t    out_data,
	output nsc_pkg::buf_status_t status
);

	nsc_pkg::verdict_t head_q;
	nsc_pkg::verdict_t skid_q;
	logic              head_v_q;
	logic              skid_v_q;
	logic              pop;

	assign pop = head_v_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			head_v_q <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			if (!head_v_q) begin
				head_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			head_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			if (!head_v_q) begin
				head_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

	assign out_valid = head_v_q;
	assign out_data = head_q;
	assign status.head_valid = head_v_q;
	assign status.skid_valid = skid_v_q;

endmodule

@@ src/nmea_sentence_checker.sv @@
// Top level of the NMEA sentence checker: APB register, line tracker and result buffer.
// Takes one text byte per cycle, every cycle, as long as the two-slot result buffer has room;
// a newline's verdict is registered into the output register, or into the skid slot while that
// register is held, as the newline is accepted; if the output register was free or being read,
// the result is visible the cycle after the newline is accepted. The input stalls only when both
// result slots are full. min_length sits at APB address 0 (reset 11); lines of MAX_LINE-1 bytes
// or more before the newline are reported as overlong at their newline and never split.
module nmea_sentence_checker #(
	parameter int MAX_LINE = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nsc_pkg::ADDR_W-1:0]    paddr,
	input  logic [nsc_pkg::DATA_W-1:0]    pwdata,
	output logic [nsc_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    data_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          sentence_ok,
	output logic [2:0]                    fault_code,
	output logic [nsc_pkg::LEN_W-1:0]     line_length,
	output logic [7:0]                    computed_checksum
);

	logic [nsc_pkg::LEN_W-1:0] min_length_q;
	logic                      reg_sel;
	logic                      in_fire;
	logic                      push;
	nsc_pkg::verdict_t         verdict;
	nsc_pkg::verdict_t         result;
	nsc_pkg::buf_status_t      buf_status;

	assign pready = 1'b1;
	assign reg_sel = (paddr[2] == nsc_pkg::REG_MIN_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= nsc_pkg::MIN_LENGTH_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			min_length_q <= pwdata[nsc_pkg::LEN_W-1:0];
		end
	end

	assign prdata = reg_sel ? {{(nsc_pkg::DATA_W - nsc_pkg::LEN_W){1'b0}}, min_length_q} : '0;

	assign in_ready = !buf_status.skid_valid;
	assign in_fire = in_valid && in_ready;
	assign push = in_fire && (data_byte == nsc_pkg::CH_NL);

	nsc_line_tracker #(
		.MAX_LINE(MAX_LINE)
	) u_tracker (
		.clk(clk),
		.arst_n(arst_n),
		.accept(in_fire),
		.data_byte(data_byte),
		.min_length(min_length_q),
		.verdict(verdict)
	);

	nsc_result_buffer u_buffer (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(verdict),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_data(result),
		.status(buf_status)
	);

	assign sentence_ok = result.ok;
	assign fault_code = result.fault;
	assign line_length = result.length;
	assign computed_checksum = result.chk;

	a_skid_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		buf_status.skid_valid |-> buf_status.head_valid)
		else $error("skid slot holds an item while the output register is empty");

	a_blocked_goes_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_valid && !out_ready) |=> buf_status.skid_valid)
		else $error("verdict lost while the output was stalled");

	a_ok_matches_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sentence_ok == (fault_code == nsc_pkg::FAULT_OK)))
		else $error("sentence_ok disagrees with fault_code");

	a_overlong_no_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fault_code == nsc_pkg::FAULT_OVERLONG) |-> (computed_checksum == 8'h00))
		else $error("overlong verdict carries a checksum");

endmodule

@@ verif/tb.sv @@
// Testbench for nmea_sentence_checker: directed line table, then random lines vs. a predictor.
`timescale 1ns / 100ps

module tb;

	localparam int LINE_CAP = 1024;
	localparam int MIN_FRAME = 6;
	localparam int SETTLE_CYCLES = 4;
	localparam int STALL_LIMIT = 3000;
	localparam int PHASE_BYTES = 215;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [nsc_pkg::ADDR_W-1:0] ADDR_MIN_LEN = {nsc_pkg::REG_MIN_LENGTH, 2'b00};
	localparam logic [nsc_pkg::ADDR_W-1:0] ADDR_SPARE = 3'd4;

	typedef enum int {
		SN_GOOD,
		SN_BADSUM,
		SN_LOWER,
		SN_BADLEAD,
		SN_BADSTAR,
		SN_ODDTAIL
	} flavor_t;

	typedef struct {
		int                cfg;
		string             body;
		int                reps;
		bit                wrap;
		bit                crlf;
		bit                typed;
		nsc_pkg::verdict_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [nsc_pkg::ADDR_W-1:0] paddr;
	logic [nsc_pkg::DATA_W-1:0] pwdata, prdata;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [7:0] data_byte;
	logic sentence_ok;
	logic [2:0] fault_code;
	logic [nsc_pkg::LEN_W-1:0] line_length;
	logic [7:0] computed_checksum;

	nmea_sentence_checker u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sentence_ok(sentence_ok),
		.fault_code(fault_code),
		.line_length(line_length),
		.computed_checksum(computed_checksum)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// line predictor state
	logic [nsc_pkg::LEN_W-1:0] cfg_min_len;
	int                        ln_count;
	logic [7:0]                ln_lead;
	logic [7:0]                ln_tail[5];
	logic [7:0]                ln_xor;
	bit                        ln_overlong;
	bit                        pin_valid;
	nsc_pkg::verdict_t         pin_verdict;

	nsc_pkg::verdict_t pending_verdicts[$];
	logic [7:0]        payload[$];
	logic [7:0]        line_bytes[$];
	row_t              rows[$];
	string             hex_glyphs = "0123456789ABCDEF";
	int                err_count;
	int                bytes_sent;
	int                idle_cycles;

	function automatic void log_mismatch(input string msg);
		err_count++;
		if (err_count <= 10) begin
			$display("mismatch: %s", msg);
		end
	endfunction

	function automatic logic [7:0] any_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == nsc_pkg::CH_NL);
		return b;
	endfunction

	function automatic logic [7:0] edge_byte();
		logic [7:0] b;
		case ($urandom_range(0, 2))
			0: b = 8'h00;
			1: b = 8'hFF;
			default: b = any_byte();
		endcase
		return b;
	endfunction

	function automatic int pick_gap();
		int r;
		int g;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			g = 0;
		end else if (r < 90) begin
			g = $urandom_range(1, 3);
		end else if (r < 98) begin
			g = $urandom_range(4, 12);
		end else begin
			g = $urandom_range(20, 50);
		end
		return g;
	endfunction

	function automatic void clear_line();
		ln_count = 0;
		ln_lead = 8'h00;
		for (int i = 0; i < 5; i++) ln_tail[i] = 8'h00;
		ln_xor = 8'h00;
		ln_overlong = 1'b0;
	endfunction

	task automatic track_byte(input logic [7:0] b);
		nsc_pkg::verdict_t v;
		int len;
		int k;
		if (b != nsc_pkg::CH_NL) begin
			if (!ln_overlong) begin
				if (ln_count == 0) begin
					ln_lead = b;
				end else begin
					ln_xor ^= b;
				end
				for (k = 4; k > 0; k--) ln_tail[k] = ln_tail[k-1];
				ln_tail[0] = b;
				ln_count++;
				if (ln_count >= LINE_CAP - 1) begin
					ln_overlong = 1'b1;
				end
			end
		end else begin
			len = ln_count + 1;
			v.ok = 1'b0;
			v.fault = nsc_pkg::FAULT_OK;
			v.chk = 8'h00;
			v.length = (len > nsc_pkg::LEN_SAT) ? nsc_pkg::LEN_SAT : nsc_pkg::LEN_W'(len);
			if (ln_overlong) begin
				v.fault = nsc_pkg::FAULT_OVERLONG;
				v.length = nsc_pkg::LEN_SAT;
			end else begin
				if (len >= MIN_FRAME) begin
					v.chk = ln_xor ^ ln_tail[0] ^ ln_tail[1] ^ ln_tail[2] ^ ln_tail[3];
				end
				if (len <= cfg_min_len) begin
					v.fault = nsc_pkg::FAULT_SHORT;
				end else if (len < MIN_FRAME || ln_lead != nsc_pkg::CH_DOLLAR
						|| ln_tail[3] != nsc_pkg::CH_STAR) begin
					v.fault = nsc_pkg::FAULT_FRAMING;
				end else if (ln_tail[2] != hex_glyphs[v.chk[7:4]]
						|| ln_tail[1] != hex_glyphs[v.chk[3:0]]) begin
					v.fault = nsc_pkg::FAULT_CHECKSUM;
				end else begin
					v.ok = 1'b1;
				end
			end
			if (pin_valid) begin
				v = pin_verdict;
				pin_valid = 1'b0;
			end
			pending_verdicts.push_back(v);
			clear_line();
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input bit quiet);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		data_byte = b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		track_byte(b);
		@(negedge clk);
	endtask

	task automatic send_line(input bit quiet);
		foreach (line_bytes[i]) send_byte(line_bytes[i], quiet);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (pending_verdicts.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apb_write(input logic [nsc_pkg::ADDR_W-1:0] a,
			input logic [nsc_pkg::DATA_W-1:0] d);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = a;
		pwdata = d;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (a == ADDR_MIN_LEN) begin
			cfg_min_len = d[nsc_pkg::LEN_W-1:0];
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic check_min_reg();
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ADDR_MIN_LEN;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[nsc_pkg::LEN_W-1:0] !== cfg_min_len) begin
			log_mismatch($sformatf("min_length read exp %0d got %0d",
				cfg_min_len, prdata[nsc_pkg::LEN_W-1:0]));
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic set_min_length(input int val);
		drain();
		apb_write(ADDR_SPARE, $urandom());
		apb_write(ADDR_MIN_LEN, {22'($urandom_range(0, (1 << 22) - 1)), 10'(val)});
		check_min_reg();
	endtask

	task automatic fill_payload(input int n, input bit binary);
		payload.delete();
		repeat (n) payload.push_back(binary ? edge_byte() : 8'($urandom_range(8'h20, 8'h7E)));
	endtask

	// wraps the payload as $<payload>*HH<cr><nl>, optionally damaged
	task automatic frame_line(input flavor_t fl);
		logic [7:0] sum;
		logic [7:0] hi;
		logic [7:0] lo;
		logic [7:0] b;
		sum = 8'h00;
		line_bytes.delete();
		if (fl == SN_BADLEAD) begin
			do b = any_byte(); while (b == nsc_pkg::CH_DOLLAR);
			line_bytes.push_back(b);
		end else begin
			line_bytes.push_back(nsc_pkg::CH_DOLLAR);
		end
		foreach (payload[i]) begin
			line_bytes.push_back(payload[i]);
			sum ^= payload[i];
		end
		if (fl == SN_BADSTAR) begin
			do b = any_byte(); while (b == nsc_pkg::CH_STAR);
			line_bytes.push_back(b);
		end else begin
			line_bytes.push_back(nsc_pkg::CH_STAR);
		end
		if (fl == SN_BADSUM) begin
			sum ^= 8'(1 << $urandom_range(0, 7));
		end
		hi = hex_glyphs[sum[7:4]];
		lo = hex_glyphs[sum[3:0]];
		if (fl == SN_LOWER) begin
			if (hi >= "A") hi = hi | 8'h20;
			if (lo >= "A") lo = lo | 8'h20;
		end
		line_bytes.push_back(hi);
		line_bytes.push_back(lo);
		line_bytes.push_back((fl == SN_ODDTAIL) ? any_byte() : CH_CR);
		line_bytes.push_back(nsc_pkg::CH_NL);
	endtask

	task automatic add_row(input int cfg, input string body, input int reps, input bit wrap,
			input bit crlf, input bit typed, input logic ok, input nsc_pkg::fault_t f,
			input int len, input logic [7:0] chk);
		row_t r;
		r.cfg = cfg;
		r.body = body;
		r.reps = reps;
		r.wrap = wrap;
		r.crlf = crlf;
		r.typed = typed;
		r.want.ok = ok;
		r.want.fault = f;
		r.want.length = nsc_pkg::LEN_W'(len);
		r.want.chk = chk;
		rows.push_back(r);
	endtask

	always @(posedge clk) begin
		nsc_pkg::verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				log_mismatch($sformatf("verdict with no line pending: ok=%0d fault=%0d len=%0d",
					sentence_ok, fault_code, line_length));
			end else begin
				want = pending_verdicts.pop_front();
				if (sentence_ok !== want.ok)
					log_mismatch($sformatf("sentence_ok exp %0d got %0d", want.ok, sentence_ok));
				if (fault_code !== want.fault)
					log_mismatch($sformatf("fault_code exp %0d got %0d", want.fault, fault_code));
				if (line_length !== want.length)
					log_mismatch($sformatf("line_length exp %0d got %0d", want.length,
						line_length));
				if (computed_checksum !== want.chk)
					log_mismatch($sformatf("computed_checksum exp %h got %h", want.chk,
						computed_checksum));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result side: runs of ready with stalls between them
	initial begin
		int run;
		int stall;
		int r;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
			out_ready = 1'b1;
			repeat (run) @(negedge clk);
			r = $urandom_range(0, 99);
			if (r < 50) begin
				stall = 0;
			end else if (r < 85) begin
				stall = $urandom_range(1, 3);
			end else if (r < 97) begin
				stall = $urandom_range(4, 10);
			end else begin
				stall = $urandom_range(20, 60);
			end
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
		end
	end

	initial begin
		int r;
		int n;
		int mark;
		int plan[7];
		bit quiet;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		err_count = 0;
		bytes_sent = 0;
		idle_cycles = 0;
		pin_valid = 1'b0;
		cfg_min_len = nsc_pkg::MIN_LENGTH_RESET;
		clear_line();

		add_row(-1, "", 1, 0, 0, 1, 1'b0, nsc_pkg::FAULT_SHORT, 1, 8'h00);
		add_row(-1, "$*", 1, 0, 1, 1, 1'b0, nsc_pkg::FAULT_SHORT, 4, 8'h00);
		add_row(-1, "", 1, 1, 1, 1, 1'b0, nsc_pkg::FAULT_SHORT, 6, 8'h00);
		add_row(-1, "GPGLL,4916.45,N,12311.12,W,225444,A", 1, 1, 1, 0, 1'b0,
			nsc_pkg::FAULT_OK, 0, 8'h00);
		add_row(0, "", 1, 0, 0, 1, 1'b0, nsc_pkg::FAULT_FRAMING, 1, 8'h00);
		add_row(-1, "", 1, 1, 1, 1, 1'b1, nsc_pkg::FAULT_OK, 6, 8'h00);
		add_row(-1, "$*", 1, 0, 1, 1, 1'b0, nsc_pkg::FAULT_FRAMING, 4, 8'h00);
		add_row(-1, "x*00", 1, 0, 1, 1, 1'b0, nsc_pkg::FAULT_FRAMING, 6, 8'h00);
		add_row(5, "", 1, 1, 1, 1, 1'b1, nsc_pkg::FAULT_OK, 6, 8'h00);
		add_row(6, "", 1, 1, 1, 1, 1'b0, nsc_pkg::FAULT_SHORT, 6, 8'h00);
		add_row(11, "GPGGA,123519,4807.038,N", 1, 1, 1, 0, 1'b0, nsc_pkg::FAULT_OK, 0, 8'h00);
		add_row(-1, "B", 1024, 0, 0, 1, 1'b0, nsc_pkg::FAULT_OVERLONG, 1023, 8'h00);
		add_row(-1, "C", 1022, 0, 0, 0, 1'b0, nsc_pkg::FAULT_OK, 0, 8'h00);
		add_row(1023, "GPRMC", 1, 1, 1, 0, 1'b0, nsc_pkg::FAULT_OK, 0, 8'h00);

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		check_min_reg();

		foreach (rows[i]) begin
			if (rows[i].cfg >= 0) begin
				set_min_length(rows[i].cfg);
			end
			payload.delete();
			line_bytes.delete();
			if (rows[i].wrap) begin
				for (int c = 0; c < rows[i].body.len(); c++) payload.push_back(rows[i].body[c]);
				frame_line(SN_GOOD);
			end else begin
				repeat (rows[i].reps) begin
					for (int c = 0; c < rows[i].body.len(); c++)
						line_bytes.push_back(rows[i].body[c]);
				end
				if (rows[i].crlf) line_bytes.push_back(CH_CR);
				line_bytes.push_back(nsc_pkg::CH_NL);
			end
			if (rows[i].typed) begin
				pin_valid = 1'b1;
				pin_verdict = rows[i].want;
			end
			send_line(1'b0);
		end

		plan = '{0, 6, 1023, 5, $urandom_range(0, 1023), 11, $urandom_range(7, 40)};
		foreach (plan[p]) begin
			set_min_length(plan[p]);
			mark = bytes_sent;
			while (bytes_sent < mark + PHASE_BYTES) begin
				r = $urandom_range(0, 99);
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 80) : $urandom_range(0, 20);
				quiet = ($urandom_range(0, 3) == 0);
				if (r < 50) begin
					fill_payload(n, 1'b0);
					frame_line(SN_GOOD);
				end else if (r < 70) begin
					fill_payload(n, 1'b0);
					frame_line(flavor_t'($urandom_range(SN_BADSUM, SN_ODDTAIL)));
				end else if (r < 78) begin
					fill_payload(n, 1'b1);
					frame_line(SN_GOOD);
				end else if (r < 88) begin
					line_bytes.delete();
					if ($urandom_range(0, 1)) line_bytes.push_back(nsc_pkg::CH_DOLLAR);
					repeat ($urandom_range(0, 10)) line_bytes.push_back(any_byte());
					line_bytes.push_back(nsc_pkg::CH_NL);
				end else begin
					line_bytes.delete();
					repeat ($urandom_range(0, 40)) line_bytes.push_back(edge_byte());
					line_bytes.push_back(nsc_pkg::CH_NL);
				end
				send_line(quiet);
				if ($urandom_range(0, 49) == 0) begin
					drain();
				end
			end
		end

		// a last line with no newline gives no verdict
		line_bytes = '{nsc_pkg::CH_DOLLAR, "G", "P"};
		send_line(1'b0);
		in_valid = 1'b0;

		while (pending_verdicts.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (pending_verdicts.size() != 0) begin
			log_mismatch("verdicts still pending at end of run");
		end
		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/nsc_pkg.sv
src/nsc_line_tracker.sv
src/nsc_result_buffer.sv
src/nmea_sentence_checker.sv
verif/tb.sv
